/* rtl/nnc_pkg.sv */
// Shared types and constants for the nearest-neighbor classifier.
`timescale 1ns / 1ps

package nnc_pkg;

    localparam int FEAT_W   = 8;
    localparam int NUM_FEAT = 4;
    localparam int CLASS_W  = 8;
    localparam int INDEX_W  = 8;
    localparam int DIST_W   = 18;
    localparam int SQ_W     = 2 * FEAT_W;
    localparam int ENTRY_W  = NUM_FEAT * FEAT_W + CLASS_W;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUERY_OK = 3'd0,
        ST_LOADED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } state_t;

endpackage

/* rtl/nearest_neighbor_classifier.sv */
// One-nearest-neighbor classifier: reference table, scan sequencer and distance unit.
`timescale 1ns / 1ps

// One-nearest-neighbor classifier over four 8-bit features. Each input word
// carries a kind in tuser (clear table, load reference, query; kind 3 acts as
// a query) and the features plus a class id in tdata. Every word yields one
// result word: status in tuser, and nearest index, class and squared distance
// in tdata. A clear, a load or an empty-table query is decided on acceptance
// into the result register and moves to the output register once that is
// free; the input is ready again after that. A query against N stored
// references scans all N entries before its result passes through the
// result register to the output register: the sequencer reads one table
// entry per cycle from a single-port table memory and feeds it to one shared
// distance unit (four 8x8 squares, registered, then a 4-way sum and compare
// against the running best). Ties keep the lowest index. Loads into a full
// table are dropped with status "table full"; queries on an empty table
// return status "empty". The block takes one word at a time; it accepts the
// next word while the previous result still waits in the output register,
// but a new result that finds the output register still occupied holds the
// block, input not ready, until the waiting word is taken. The table has no
// reset; only entries below the reference count are ever used.
module nearest_neighbor_classifier #(
    parameter int MAX_REFS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] sepal_length, [15:8] sepal_width, [23:16] petal_length,
    // [31:24] petal_width, [39:32] class_id
    input  logic [nnc_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // [1:0] kind
    input  logic [nnc_pkg::KIND_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] nearest_index, [15:8] nearest_class, [33:16] nearest_distance,
    // [39:34] zero
    output logic [nnc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // [2:0] status
    output logic [nnc_pkg::STATUS_W-1:0]          m_axis_tuser
);

    localparam int CNT_W = $clog2(MAX_REFS + 1);
    localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int FW    = nnc_pkg::FEAT_W;
    localparam int NF    = nnc_pkg::NUM_FEAT;
    localparam int CW    = nnc_pkg::CLASS_W;
    localparam int DW    = nnc_pkg::DIST_W;
    localparam int SW    = nnc_pkg::SQ_W;
    localparam int EW    = nnc_pkg::ENTRY_W;

    // control state
    nnc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             issue_reg, issue_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             out_valid_reg, out_valid_next;

    // datapath
    logic [NF*FW-1:0]    query_reg, query_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                last1_reg, last1_next;
    logic [IDX_W-1:0]    idx1_reg, idx1_next;
    logic                last2_reg, last2_next;
    logic [IDX_W-1:0]    idx2_reg, idx2_next;
    logic [CW-1:0]       cls2_reg, cls2_next;
    logic [SW-1:0]       sq_reg [NF];
    logic [SW-1:0]       sq_next [NF];
    logic [DW-1:0]       best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [CW-1:0]       best_cls_reg, best_cls_next;
    nnc_pkg::status_t    res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [CW-1:0]       res_cls_reg, res_cls_next;
    logic [DW-1:0]       res_dist_reg, res_dist_next;
    nnc_pkg::status_t    out_status_reg, out_status_next;
    logic [nnc_pkg::INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic [CW-1:0]       out_cls_reg, out_cls_next;
    logic [DW-1:0]       out_dist_reg, out_dist_next;

    // reference table
    logic [EW-1:0]       table_mem [MAX_REFS];
    logic [EW-1:0]       rdata_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;

    // combinational helpers
    logic                accept;
    logic                out_free;
    logic                last_issue;
    logic [FW-1:0]       feat_a, feat_b, feat_d;
    logic [DW-1:0]       dist_sum;
    logic                better;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == nnc_pkg::S_IDLE);
    assign last_issue = (CNT_W'(addr_reg) == (cnt_reg - CNT_W'(1)));

    // distance unit, stage 3: sum and compare against the running best
    assign dist_sum = DW'(sq_reg[0]) + DW'(sq_reg[1]) + DW'(sq_reg[2]) + DW'(sq_reg[3]);
    assign better   = (dist_sum < best_dist_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        out_valid_next  = out_valid_reg;
        query_next      = query_reg;
        addr_next       = addr_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        best_cls_next   = best_cls_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_cls_next    = res_cls_reg;
        res_dist_next   = res_dist_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_cls_next    = out_cls_reg;
        out_dist_next   = out_dist_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[IDX_W-1:0];

        // stage 1: table read in flight
        v1_next    = (state_reg == nnc_pkg::S_SCAN) && issue_reg;
        last1_next = last_issue;
        idx1_next  = addr_reg;

        // stage 2: squared differences of the entry just read
        v2_next    = v1_reg;
        last2_next = last1_reg;
        idx2_next  = idx1_reg;
        cls2_next  = rdata_reg[NF*FW +: CW];
        feat_a = '0;
        feat_b = '0;
        feat_d = '0;
        for (int k = 0; k < NF; k++)
        begin
            feat_a = rdata_reg[k*FW +: FW];
            feat_b = query_reg[k*FW +: FW];
            feat_d = (feat_a > feat_b) ? (feat_a - feat_b) : (feat_b - feat_a);
            sq_next[k] = feat_d * feat_d;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nnc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_idx_next  = '0;
                    res_cls_next  = '0;
                    res_dist_next = '0;
                    state_next    = nnc_pkg::S_WAIT;
                    unique case (nnc_pkg::kind_t'(s_axis_tuser))
                        nnc_pkg::KIND_CLEAR:
                        begin
                            cnt_next        = '0;
                            res_status_next = nnc_pkg::ST_CLEARED;
                        end
                        nnc_pkg::KIND_LOAD:
                        begin
                            if (cnt_reg != CNT_W'(MAX_REFS))
                            begin
                                mem_we          = 1'b1;
                                res_idx_next    = cnt_reg[IDX_W-1:0];
                                cnt_next        = cnt_reg + CNT_W'(1);
                                res_status_next = nnc_pkg::ST_LOADED;
                            end
                            else
                            begin
                                res_status_next = nnc_pkg::ST_FULL;
                            end
                        end
                        default:
                        begin
                            // query (kind 3 decodes the same way)
                            if (cnt_reg == '0)
                            begin
                                res_status_next = nnc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                query_next     = s_axis_tdata[NF*FW-1:0];
                                addr_next      = '0;
                                issue_next     = 1'b1;
                                best_dist_next = '1;
                                best_idx_next  = '0;
                                best_cls_next  = '0;
                                state_next     = nnc_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end
            nnc_pkg::S_SCAN:
            begin
                if (issue_reg)
                begin
                    if (last_issue)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + IDX_W'(1);
                    end
                end
                if (v2_reg)
                begin
                    // strict compare: lowest index wins on a tie
                    if (better)
                    begin
                        best_dist_next = dist_sum;
                        best_idx_next  = idx2_reg;
                        best_cls_next  = cls2_reg;
                    end
                    if (last2_reg)
                    begin
                        res_status_next = nnc_pkg::ST_QUERY_OK;
                        res_dist_next   = better ? dist_sum : best_dist_reg;
                        res_idx_next    = better ? idx2_reg : best_idx_reg;
                        res_cls_next    = better ? cls2_reg : best_cls_reg;
                        state_next      = nnc_pkg::S_WAIT;
                    end
                end
            end
            nnc_pkg::S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = nnc_pkg::INDEX_W'(res_idx_reg);
                    out_cls_next    = res_cls_reg;
                    out_dist_next   = res_dist_reg;
                    state_next      = nnc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nnc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nnc_pkg::S_IDLE;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg      <= query_next;
        addr_reg       <= addr_next;
        last1_reg      <= last1_next;
        idx1_reg       <= idx1_next;
        last2_reg      <= last2_next;
        idx2_reg       <= idx2_next;
        cls2_reg       <= cls2_next;
        for (int k = 0; k < NF; k++)
        begin
            sq_reg[k] <= sq_next[k];
        end
        best_dist_reg  <= best_dist_next;
        best_idx_reg   <= best_idx_next;
        best_cls_reg   <= best_cls_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_cls_reg    <= res_cls_next;
        res_dist_reg   <= res_dist_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_cls_reg    <= out_cls_next;
        out_dist_reg   <= out_dist_next;
    end

    // single-port table: write on load, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= s_axis_tdata[EW-1:0];
        end
        rdata_reg <= table_mem[addr_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {
        (nnc_pkg::OUT_DATA_W - nnc_pkg::INDEX_W - CW - DW)'(0),
        out_dist_reg, out_cls_reg, out_idx_reg
    };

endmodule

/* tb/sv/nearest_neighbor_classifier_test.sv */
// Self-checking testbench for the nearest-neighbor classifier.
`timescale 1ns / 1ps

module nearest_neighbor_classifier_test;

    localparam int TABLE_DEPTH  = 256;
    localparam int TOTAL_WORDS  = 1150;
    localparam int IDLE_PCT     = 24;
    localparam int DRAIN_CYCLES = 300;      // longer than a full-table query
    localparam int CYCLE_LIMIT  = 2000000;

    // Kind code 3 is not in the package enum; the block decodes it as a query.
    localparam logic [nnc_pkg::KIND_W-1:0] KIND_QUERY_ALIAS = 2'd3;

    // Tracks the reference table and the results it must produce.
    class classifier_scoreboard;
        typedef struct packed {
            nnc_pkg::status_t status;
            logic [7:0]       index;
            logic [7:0]       cls;
            logic [17:0]      sq_distance;
        } result_t;

        logic [nnc_pkg::IN_DATA_W-1:0] ref_table [TABLE_DEPTH];
        int unsigned                   ref_count;
        result_t                       expected_q [$];
        int                            errors;

        function new();
            ref_count = 0;
            errors    = 0;
        endfunction

        // Predict the result of one accepted input word.
        function void note_accepted(logic [nnc_pkg::KIND_W-1:0] kind,
                                    logic [nnc_pkg::IN_DATA_W-1:0] word);
            result_t     r;
            int unsigned best;
            int unsigned sum;
            int unsigned a;
            int unsigned b;
            int unsigned d;
            r = '0;
            if (kind == nnc_pkg::KIND_CLEAR)
            begin
                ref_count = 0;
                r.status  = nnc_pkg::ST_CLEARED;
            end
            else if (kind == nnc_pkg::KIND_LOAD)
            begin
                if (ref_count < TABLE_DEPTH)
                begin
                    ref_table[ref_count] = word;
                    r.status  = nnc_pkg::ST_LOADED;
                    r.index   = 8'(ref_count);
                    ref_count = ref_count + 1;
                end
                else
                begin
                    r.status = nnc_pkg::ST_FULL;
                end
            end
            else if (ref_count == 0)
            begin
                r.status = nnc_pkg::ST_EMPTY;
            end
            else
            begin
                best = 32'hFFFF_FFFF;
                for (int unsigned i = 0; i < ref_count; i++)
                begin
                    sum = 0;
                    for (int k = 0; k < nnc_pkg::NUM_FEAT; k++)
                    begin
                        a = word[8*k +: 8];
                        b = ref_table[i][8*k +: 8];
                        d = (a > b) ? a - b : b - a;
                        sum += d * d;
                    end
                    // strict compare keeps the lowest index on a tie
                    if (sum < best)
                    begin
                        best    = sum;
                        r.index = 8'(i);
                        r.cls   = ref_table[i][39:32];
                    end
                end
                r.status      = nnc_pkg::ST_QUERY_OK;
                r.sq_distance = 18'(best);
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one accepted result word against the oldest prediction.
        function void check_result(logic [nnc_pkg::STATUS_W-1:0] status,
                                   logic [nnc_pkg::OUT_DATA_W-1:0] word);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, status, word);
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("status",           exp_r.status,      status);
            compare_field("nearest_index",    exp_r.index,       word[7:0]);
            compare_field("nearest_class",    exp_r.cls,         word[15:8]);
            compare_field("nearest_distance", exp_r.sq_distance, word[33:16]);
            compare_field("padding",          0,                 word[39:34]);
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // sepal_length, sepal_width, petal_length, petal_width, class_id
    logic [nnc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [nnc_pkg::KIND_W-1:0]     s_axis_tuser;   // kind
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // nearest_index, nearest_class, nearest_distance, zero pad
    logic [nnc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [nnc_pkg::STATUS_W-1:0]   m_axis_tuser;   // status

    classifier_scoreboard sb = new();
    int unsigned          words_sent = 0;
    int unsigned          cycles     = 0;
    bit                   no_idle    = 1'b0;

    nearest_neighbor_classifier #(
        .MAX_REFS (TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic logic [nnc_pkg::IN_DATA_W-1:0] pack_word(logic [31:0] sample,
                                                                logic [7:0] cls);
        return {cls, sample};
    endfunction

    // Four features; narrow draws cluster values so that ties are common.
    function automatic logic [31:0] rand_sample(bit narrow);
        logic [31:0] s;
        for (int k = 0; k < nnc_pkg::NUM_FEAT; k++)
        begin
            if (narrow)
                s[8*k +: 8] = 8'($urandom_range(100, 102));
            else if ($urandom_range(0, 9) == 0)
                s[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                s[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return s;
    endfunction

    task automatic send_word(logic [nnc_pkg::KIND_W-1:0] kind,
                             logic [nnc_pkg::IN_DATA_W-1:0] word);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_accepted(kind, word);
        words_sent++;
        // one long stretch with no idling on either side
        no_idle = (words_sent >= 350 && words_sent < 550);
    endtask

    task automatic load_ref(logic [31:0] sample, logic [7:0] cls);
        send_word(nnc_pkg::KIND_LOAD, pack_word(sample, cls));
    endtask

    // Query with junk in the class field, which the block must ignore.
    task automatic query_nearest(logic [31:0] sample);
        send_word($urandom_range(0, 3) == 0 ? KIND_QUERY_ALIAS : nnc_pkg::KIND_QUERY,
                  pack_word(sample, 8'($urandom_range(0, 255))));
    endtask

    task automatic clear_table();
        send_word(nnc_pkg::KIND_CLEAR,
                  pack_word(32'($urandom), 8'($urandom_range(0, 255))));
    endtask

    // Fill the table to capacity, push loads past it, then query the full table.
    task automatic fill_table();
        clear_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_ref(rand_sample($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 3))
            load_ref(rand_sample(1'b0), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(2, 4))
            query_nearest(rand_sample(1'($urandom_range(0, 1))));
    endtask

    // Clear (usually), load a small set, then query it, with loads mixed in.
    task automatic classify_session();
        logic [31:0] loaded [$];
        logic [31:0] s;
        bit          narrow;
        int          n_refs;
        narrow = 1'($urandom_range(0, 1));
        n_refs = $urandom_range(1, 20);
        if ($urandom_range(0, 99) < 70)
            clear_table();
        repeat (n_refs)
        begin
            s = rand_sample(narrow);
            loaded.push_back(s);
            load_ref(s, 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 9) < 3)
                query_nearest(loaded[$urandom_range(0, loaded.size() - 1)]);
            else
                query_nearest(rand_sample(narrow));
            if ($urandom_range(0, 9) == 0)
                load_ref(rand_sample(narrow), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = nnc_pkg::KIND_CLEAR;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, exact match, tie, alias kind, re-clear
        query_nearest(32'hFFFF_FFFF);                       // empty after reset
        clear_table();                                      // clear on empty
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h0000_0000, 8'h00));
        load_ref(32'h0000_0000, 8'h00);
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'hFFFF_FFFF, 8'hFF)); // largest distance
        load_ref(32'hFFFF_FFFF, 8'hFF);
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h0000_0000, 8'hAA)); // exact match
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h8080_8080, 8'h55));
        load_ref(32'h0000_0000, 8'h07);                     // duplicate of slot 0
        send_word(KIND_QUERY_ALIAS, pack_word(32'h0101_0101, 8'h00)); // tie, lowest wins
        load_ref(32'hAA55_AA55, 8'hAA);
        load_ref(32'h55AA_55AA, 8'h55);
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h55AA_55AA, 8'hFF));
        send_word(KIND_QUERY_ALIAS, pack_word(32'hAA55_AA55, 8'h00));
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h7F80_7F80, 8'h00));
        clear_table();
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h1234_5678, 8'h9A)); // empty after clear
        load_ref(32'hFF00_FF00, 8'h80);                     // lands in slot 0 again
        send_word(nnc_pkg::KIND_QUERY, pack_word(32'h00FF_00FF, 8'h01));

        // random: one full-table pass first, then mostly well-formed sessions
        fill_table();
        while (words_sent < TOTAL_WORDS)
        begin
            case ($urandom_range(0, 99)) inside
                [0:3]:   fill_table();
                [4:84]:  classify_session();
                default:
                    repeat ($urandom_range(1, 5))
                        send_word(nnc_pkg::KIND_W'($urandom_range(0, 3)),
                                  pack_word(rand_sample(1'b0), 8'($urandom_range(0, 255))));
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/nnc_pkg.sv
rtl/nearest_neighbor_classifier.sv
tb/sv/nearest_neighbor_classifier_test.sv
